@@ src/pbcp_pkg.sv @@
`timescale 1ns / 1ps

package pbcp_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int TRACE_MAX   = 4096;
    localparam int POS_W       = $clog2(TRACE_MAX);
    localparam int POS_CNT_W   = POS_W + 1;

    localparam int LEN_W       = 12;
    localparam int IDX_W       = 12;
    localparam int PSUM_W      = 20;
    localparam int SQ_W        = 27;
    localparam int SSUM_W      = 21;
    localparam int CNT_W       = 12;
    localparam int SQ_SAMPLE_W = 2 * SAMPLE_BITS - 1;

    localparam int BASE_W      = 21;
    localparam int VAR_W       = 39;
    localparam int CHARGE_W    = 34;
    localparam int MINL_W      = SAMPLE_BITS + LEN_W + 1;
    localparam int PROD_W      = CNT_W + PSUM_W + 1;

    localparam int CFG_DATA_W  = 39;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PEDESTAL_LENGTH = 3'd0,
        CFG_SIGNAL_START    = 3'd1,
        CFG_SIGNAL_LENGTH   = 3'd2,
        CFG_QUIET_LIMIT     = 3'd3,
        CFG_PEAK_SIGNAL     = 3'd4,
        CFG_CHARGE_GATE     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [LEN_W-1:0]           pedestal_length;
        logic [LEN_W-1:0]           signal_start;
        logic [LEN_W-1:0]           signal_length;
        logic [VAR_W-1:0]           quiet_limit;
        logic                       peak_in_signal_only;
        logic signed [CHARGE_W-1:0] charge_gate;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        pedestal_length:     12'd500,
        signal_start:        12'd500,
        signal_length:       12'd2002,
        quiet_limit:         39'd0,
        peak_in_signal_only: 1'b0,
        charge_gate:         34'h3_0000_0000
    };

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef struct packed {
        logic signed [PSUM_W-1:0]      pedestal_sum;
        logic [SQ_W-1:0]               square_sum;
        logic signed [SSUM_W-1:0]      signal_sum;
        logic [CNT_W-1:0]              signal_count;
        logic signed [SAMPLE_BITS-1:0] minimum_value;
        logic [IDX_W-1:0]              minimum_position;
    } trace_sums_t;

    localparam trace_sums_t TRACE_CLEAR = '{
        pedestal_sum:     '0,
        square_sum:       '0,
        signal_sum:       '0,
        signal_count:     '0,
        minimum_value:    SAMPLE_MAX,
        minimum_position: '0
    };

endpackage

@@ src/pbcp_if.sv @@
`timescale 1ns / 1ps

interface pbcp_sample_if import pbcp_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface pbcp_result_if import pbcp_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [BASE_W-1:0]   baseline_sum;
    logic [VAR_W-1:0]           variance_scaled;
    logic                       quiet;
    logic signed [CHARGE_W-1:0] charge_scaled;
    logic [IDX_W-1:0]           peak_index;
    logic                       peak_found;

    modport source (
        output valid, output baseline_sum, output variance_scaled, output quiet,
        output charge_scaled, output peak_index, output peak_found, input ready
    );
    modport sink (
        input valid, input baseline_sum, input variance_scaled, input quiet,
        input charge_scaled, input peak_index, input peak_found, output ready
    );
endinterface

@@ src/pbcp_accum.sv @@
`timescale 1ns / 1ps

module pbcp_accum import pbcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    pbcp_sample_if.sink samples,
    output logic        sums_valid,
    input  logic        sums_ready,
    output trace_sums_t sums
);

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_last_reg;

    logic [POS_CNT_W-1:0] pos_reg;
    logic [POS_CNT_W-1:0] pos_next;
    trace_sums_t          acc_reg;
    trace_sums_t          acc_next;

    logic        fin_valid_reg;
    trace_sums_t fin_reg;

    logic                            in_ready;
    logic                            fin_ready;
    logic                            advance;
    logic                            active;
    logic                            in_pedestal;
    logic                            in_signal;
    logic                            take_min;
    logic [POS_CNT_W-1:0]            sig_end;
    logic signed [2*SAMPLE_BITS-1:0] sq_full;

    assign fin_ready     = !fin_valid_reg || sums_ready;
    // A sample that does not close a trace never waits on the finish stage.
    assign advance       = in_valid_reg && (!in_last_reg || fin_ready);
    assign in_ready      = !in_valid_reg || advance;
    assign samples.ready = in_ready;

    assign sig_end     = POS_CNT_W'(cfg.signal_start) + POS_CNT_W'(cfg.signal_length);
    assign active      = pos_reg < POS_CNT_W'(TRACE_MAX);
    assign in_pedestal = active && (pos_reg < POS_CNT_W'(cfg.pedestal_length));
    assign in_signal   = active && (pos_reg >= POS_CNT_W'(cfg.signal_start))
                         && (pos_reg < sig_end);
    assign take_min    = active && (!cfg.peak_in_signal_only || in_signal)
                         && (in_sample_reg < acc_reg.minimum_value);
    assign sq_full     = in_sample_reg * in_sample_reg;
    assign pos_next    = active ? pos_reg + POS_CNT_W'(1) : pos_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (in_pedestal)
        begin
            acc_next.pedestal_sum = acc_reg.pedestal_sum + PSUM_W'(in_sample_reg);
            acc_next.square_sum   = acc_reg.square_sum + SQ_W'(sq_full[SQ_SAMPLE_W-1:0]);
        end
        if (in_signal)
        begin
            acc_next.signal_sum   = acc_reg.signal_sum + SSUM_W'(in_sample_reg);
            acc_next.signal_count = acc_reg.signal_count + CNT_W'(1);
        end
        if (take_min)
        begin
            acc_next.minimum_value    = in_sample_reg;
            acc_next.minimum_position = pos_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            acc_reg       <= TRACE_CLEAR;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= samples.valid;
            end
            if (advance)
            begin
                if (in_last_reg)
                begin
                    pos_reg <= '0;
                    acc_reg <= TRACE_CLEAR;
                end
                else
                begin
                    pos_reg <= pos_next;
                    acc_reg <= acc_next;
                end
            end
            if (advance && in_last_reg)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (sums_ready)
            begin
                fin_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && in_ready)
        begin
            in_sample_reg <= samples.sample;
            in_last_reg   <= samples.last_sample;
        end
        if (advance && in_last_reg)
        begin
            fin_reg <= acc_next;
        end
    end

    assign sums_valid = fin_valid_reg;
    assign sums       = fin_reg;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CNT_W'(TRACE_MAX))
        else $error("sample position ran past the trace limit");

    a_trace_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> pos_reg == '0 && acc_reg.minimum_value == SAMPLE_MAX
            && acc_reg.signal_count == '0)
        else $error("trace state not cleared after the closing word");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !sums_ready |=> fin_valid_reg && $stable(fin_reg))
        else $error("finished trace sums changed while stalled");
`endif

endmodule

@@ src/pbcp_finish.sv @@
`timescale 1ns / 1ps

module pbcp_finish import pbcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          sums_valid,
    output logic          sums_ready,
    input  trace_sums_t   sums,
    pbcp_result_if.source results
);

    typedef struct packed {
        logic [VAR_W-1:0]          len_sq;
        logic [VAR_W-1:0]          base_sq;
        logic signed [PROD_W-1:0]  cnt_base;
        logic signed [PROD_W-1:0]  len_sig;
        logic signed [MINL_W-1:0]  min_len;
        logic signed [PSUM_W-1:0]  pedestal_sum;
        logic [IDX_W-1:0]          minimum_position;
    } prod_t;

    logic  prod_valid_reg;
    prod_t prod_reg;
    prod_t prod_next;
    logic  prod_ready;

    logic                       out_valid_reg;
    logic                       out_ready;
    logic signed [BASE_W-1:0]   base_reg;
    logic [VAR_W-1:0]           var_reg;
    logic                       quiet_reg;
    logic signed [CHARGE_W-1:0] charge_reg;
    logic [IDX_W-1:0]           index_reg;
    logic                       found_reg;

    logic signed [2*PSUM_W-1:0] base_sq_full;
    logic signed [VAR_W+1:0]    var_full;
    logic [VAR_W-1:0]           var_next;
    logic signed [CHARGE_W-1:0] charge_next;
    logic                       found_next;

    assign out_ready  = !out_valid_reg || results.ready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign sums_ready = prod_ready;

    // Products of the final sums; the scale L is the pedestal length.
    assign base_sq_full = (2*PSUM_W)'(sums.pedestal_sum) * (2*PSUM_W)'(sums.pedestal_sum);

    always_comb
    begin
        prod_next.len_sq   = VAR_W'(cfg.pedestal_length) * VAR_W'(sums.square_sum);
        prod_next.base_sq  = base_sq_full[VAR_W-1:0];
        prod_next.cnt_base = PROD_W'(signed'({1'b0, sums.signal_count}))
                             * PROD_W'(sums.pedestal_sum);
        prod_next.len_sig  = PROD_W'(signed'({1'b0, cfg.pedestal_length}))
                             * PROD_W'(sums.signal_sum);
        prod_next.min_len  = MINL_W'(sums.minimum_value)
                             * MINL_W'(signed'({1'b0, cfg.pedestal_length}));
        prod_next.pedestal_sum     = sums.pedestal_sum;
        prod_next.minimum_position = sums.minimum_position;
    end

    assign var_full    = signed'({2'b00, prod_reg.len_sq}) - signed'({2'b00, prod_reg.base_sq});
    assign var_next    = var_full[VAR_W+1] ? '0 : var_full[VAR_W-1:0];
    assign charge_next = CHARGE_W'(prod_reg.cnt_base) - CHARGE_W'(prod_reg.len_sig);
    // The minimum lies strictly below the baseline when min * L < P.
    assign found_next  = (prod_reg.min_len < MINL_W'(prod_reg.pedestal_sum))
                         && (charge_next > cfg.charge_gate);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
            begin
                prod_valid_reg <= sums_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sums_valid && prod_ready)
        begin
            prod_reg <= prod_next;
        end
        if (prod_valid_reg && out_ready)
        begin
            base_reg   <= BASE_W'(prod_reg.pedestal_sum);
            var_reg    <= var_next;
            quiet_reg  <= var_next < cfg.quiet_limit;
            charge_reg <= charge_next;
            index_reg  <= found_next ? prod_reg.minimum_position : '0;
            found_reg  <= found_next;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.baseline_sum    = base_reg;
    assign results.variance_scaled = var_reg;
    assign results.quiet           = quiet_reg;
    assign results.charge_scaled   = charge_reg;
    assign results.peak_index      = index_reg;
    assign results.peak_found      = found_reg;

`ifndef SYNTHESIS
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> index_reg == '0)
        else $error("peak index set without a found peak");

    a_sums_taken: assert property (@(posedge clk) disable iff (!rst_n)
        sums_valid && sums_ready |=> prod_valid_reg)
        else $error("accepted trace sums were lost");

    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && !out_ready |=> prod_valid_reg && $stable(prod_reg))
        else $error("product stage changed while stalled");
`endif

endmodule

@@ src/pulse_baseline_charge_peak_core.sv @@
`timescale 1ns / 1ps
// A trace's result is registered, after the edge that accepts its last sample word, through
// the trace sum snapshot, the product register and the result register, in that order.
// Throughput while results.ready is high: one sample word and, even for one-sample traces,
// one result per cycle. Rate is set by the combinational accumulate over the input register.
// Reset (rst_n, asynchronous, active low) clears the trace state and loads register defaults.

module pulse_baseline_charge_peak_core import pbcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pbcp_sample_if.sink            samples,
    pbcp_result_if.source          results
);

    cfg_t        cfg_reg;
    logic        sums_valid;
    logic        sums_ready;
    trace_sums_t sums;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PEDESTAL_LENGTH: cfg_reg.pedestal_length     <= cfg_data[LEN_W-1:0];
                CFG_SIGNAL_START:    cfg_reg.signal_start        <= cfg_data[LEN_W-1:0];
                CFG_SIGNAL_LENGTH:   cfg_reg.signal_length       <= cfg_data[LEN_W-1:0];
                CFG_QUIET_LIMIT:     cfg_reg.quiet_limit         <= cfg_data[VAR_W-1:0];
                CFG_PEAK_SIGNAL:     cfg_reg.peak_in_signal_only <= cfg_data[0];
                CFG_CHARGE_GATE:     cfg_reg.charge_gate <= signed'(cfg_data[CHARGE_W-1:0]);
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    pbcp_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .samples    (samples),
        .sums_valid (sums_valid),
        .sums_ready (sums_ready),
        .sums       (sums)
    );

    pbcp_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sums_valid (sums_valid),
        .sums_ready (sums_ready),
        .sums       (sums),
        .results    (results)
    );

endmodule
